### src/region_table_overlap_guard_assert.svh
// ---------------------------------------------------------------------------
// Region table overlap guard: assertion macros
// Clocked on i_clk, quiet while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef REGION_TABLE_OVERLAP_GUARD_ASSERT_SVH
`define REGION_TABLE_OVERLAP_GUARD_ASSERT_SVH

// same-cycle implication
`define RTOG_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RTOG_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/rtog_pkg.sv
// ---------------------------------------------------------------------------
// Region table overlap guard package
// Table size, widths, command, status and failure codes, shared types.
// ---------------------------------------------------------------------------
package rtog_pkg;

    localparam int unsigned SLOTS   = 16;
    localparam int unsigned IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned CNT_W   = $clog2(SLOTS + 1);
    localparam int unsigned ADDR_W  = 64;
    localparam int unsigned OWNER_W = 32;
    localparam int unsigned REG_W   = 2 * ADDR_W;
    localparam int unsigned MARK_W  = 2 * ADDR_W + OWNER_W;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_CLAIM  = 2'd1;
    localparam logic [1:0] CMD_FREEZE = 2'd2;
    localparam logic [1:0] CMD_NOTE   = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_OVERLAP   = 3'd2;
    localparam logic [2:0] ST_BAD_INDEX = 3'd3;
    localparam logic [2:0] ST_OOB       = 3'd4;
    localparam logic [2:0] ST_LATE      = 3'd5;

    localparam logic [1:0] FAIL_NONE    = 2'd0;
    localparam logic [1:0] FAIL_OVERLAP = 2'd1;
    localparam logic [1:0] FAIL_OOB     = 2'd2;
    localparam logic [1:0] FAIL_LATE    = 2'd3;

    typedef struct packed {
        logic carry;
        logic gt0;
        logic gt1;
    } t_alu_flags;

endpackage

### src/rtog_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module rtog_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/rtog_alu.sv
// ---------------------------------------------------------------------------
// Region table shared arithmetic unit
// One 64-bit adder with carry out and two unsigned magnitude compares.
// ---------------------------------------------------------------------------
module rtog_alu (
    input  logic [rtog_pkg::ADDR_W-1:0] i_add_a,
    input  logic [rtog_pkg::ADDR_W-1:0] i_add_b,
    input  logic [rtog_pkg::ADDR_W-1:0] i_cmp0_a,
    input  logic [rtog_pkg::ADDR_W-1:0] i_cmp0_b,
    input  logic [rtog_pkg::ADDR_W-1:0] i_cmp1_b,
    output logic [rtog_pkg::ADDR_W-1:0] o_sum,
    output rtog_pkg::t_alu_flags        o_flags
);
    import rtog_pkg::*;

    logic [ADDR_W:0] w_sum;

    assign w_sum         = {1'b0, i_add_a} + {1'b0, i_add_b};
    assign o_sum         = w_sum[ADDR_W-1:0];
    assign o_flags.carry = w_sum[ADDR_W];
    assign o_flags.gt0   = (i_cmp0_a > i_cmp0_b);
    assign o_flags.gt1   = (w_sum[ADDR_W-1:0] > i_cmp1_b);

endmodule

### src/region_table_overlap_guard.sv
// Freeze, note-alloc, full/frozen add and bad-index claim strobe o_valid in
// the cycle after the transfer; claim steps through prep, check and peak
// (ending at check when out of bounds); add steps through prep and a scan that ends early on overlap.
// Add walks the table one slot per cycle through the shared adder/compare
// unit and the registered RAM read port; a new start is taken in the cycle
// the result strobes. Synchronous active-low reset empties and unfreezes.
// ---------------------------------------------------------------------------
// Region table overlap guard
// Sequencer, region/mark RAMs and table state around a shared 64-bit unit.
// ---------------------------------------------------------------------------
module region_table_overlap_guard (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_cmd,
    input  logic [rtog_pkg::ADDR_W-1:0]   i_region_base,
    input  logic [rtog_pkg::ADDR_W-1:0]   i_region_size,
    input  logic [rtog_pkg::OWNER_W-1:0]  i_owner_id,
    input  logic [7:0]                    i_slot_index,
    input  logic [rtog_pkg::ADDR_W-1:0]   i_claim_offset,
    input  logic [rtog_pkg::ADDR_W-1:0]   i_claim_length,
    output logic                          o_valid,
    output logic                          o_accepted,
    output logic [2:0]                    o_status,
    output logic [1:0]                    o_last_failure,
    output logic [rtog_pkg::ADDR_W-1:0]   o_claim_used,
    output logic [rtog_pkg::ADDR_W-1:0]   o_claim_peak,
    output logic [31:0]                   o_late_alloc_count,
    output logic [7:0]                    o_region_count
);
    import rtog_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_PEAK = 3'd4;

    logic [2:0]         r_state, n_state;
    logic [1:0]         r_cmd;
    logic [ADDR_W-1:0]  r_a, r_b;
    logic [OWNER_W-1:0] r_owner;
    logic [IDX_W-1:0]   r_slot;
    logic [ADDR_W-1:0]  r_end, n_end;
    logic               r_carry, n_carry;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic               r_cmp_vld, n_cmp_vld;
    logic [ADDR_W-1:0]  r_used, n_used;

    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_frozen, n_frozen;
    logic [31:0]        r_late, n_late;
    logic [1:0]         r_fail, n_fail;
    logic [SLOTS-1:0]   r_locked, n_locked;

    logic               r_valid, n_valid;
    logic               r_acc, n_acc;
    logic [2:0]         r_status, n_status;
    logic [ADDR_W-1:0]  r_cu, n_cu;
    logic [ADDR_W-1:0]  r_cp, n_cp;

    logic               w_take;
    logic               w_issue;
    logic [SLOTS-1:0]   w_mask;
    logic [IDX_W-1:0]   w_raddr;
    logic               w_rg_we, w_mk_we;
    logic [IDX_W-1:0]   w_mk_waddr;
    logic [MARK_W-1:0]  w_mk_wdata;
    logic [REG_W-1:0]   w_rg_rd;
    logic [MARK_W-1:0]  w_mk_rd;
    logic [ADDR_W-1:0]  w_old_base, w_old_size, w_old_used, w_old_peak;
    logic [OWNER_W-1:0] w_old_owner;
    logic [ADDR_W-1:0]  w_add_a, w_add_b, w_cmp0_a, w_cmp0_b, w_cmp1_b;
    logic [ADDR_W-1:0]  w_sum;
    logic [ADDR_W-1:0]  w_new_peak;
    t_alu_flags         w_flags;

    assign busy   = (r_state != S_IDLE);
    assign w_take = start && !busy;

    assign w_old_base  = w_rg_rd[REG_W-1:ADDR_W];
    assign w_old_size  = w_rg_rd[ADDR_W-1:0];
    assign w_old_used  = w_mk_rd[MARK_W-1:ADDR_W+OWNER_W];
    assign w_old_peak  = w_mk_rd[ADDR_W+OWNER_W-1:OWNER_W];
    assign w_old_owner = w_mk_rd[OWNER_W-1:0];

    assign w_issue    = (r_idx < r_count);
    assign w_raddr    = (r_state == S_SCAN) ? r_idx[IDX_W-1:0] : r_slot;
    assign w_new_peak = w_flags.gt0 ? r_used : w_old_peak;

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            w_mask[i] = (CNT_W'(i) < r_count);
        end
    end

    always_comb begin
        w_add_a  = r_a;
        w_add_b  = r_b;
        w_cmp0_a = r_end;
        w_cmp0_b = w_old_base;
        w_cmp1_b = r_a;
        unique case (r_state)
            S_SCAN: begin
                w_add_a  = w_old_base;
                w_add_b  = w_old_size;
                w_cmp0_b = w_old_base;
                w_cmp1_b = r_a;
            end
            S_CHK: begin
                w_add_a  = r_end;
                w_add_b  = '0;
                w_cmp0_b = w_old_size;
                w_cmp1_b = w_old_used;
            end
            S_PEAK: begin
                w_cmp0_a = r_used;
                w_cmp0_b = w_old_peak;
            end
            default: begin
            end
        endcase
    end

    rtog_alu u_alu (
        .i_add_a  (w_add_a),
        .i_add_b  (w_add_b),
        .i_cmp0_a (w_cmp0_a),
        .i_cmp0_b (w_cmp0_b),
        .i_cmp1_b (w_cmp1_b),
        .o_sum    (w_sum),
        .o_flags  (w_flags)
    );

    always_comb begin
        n_state    = r_state;
        n_end      = r_end;
        n_carry    = r_carry;
        n_idx      = r_idx;
        n_cmp_vld  = 1'b0;
        n_used     = r_used;
        n_count    = r_count;
        n_frozen   = r_frozen;
        n_late     = r_late;
        n_fail     = r_fail;
        n_locked   = r_locked;
        n_valid    = 1'b0;
        n_acc      = 1'b0;
        n_status   = ST_OK;
        n_cu       = '0;
        n_cp       = '0;
        w_rg_we    = 1'b0;
        w_mk_we    = 1'b0;
        w_mk_waddr = r_slot;
        w_mk_wdata = {r_used, w_new_peak, w_old_owner};
        unique case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    unique case (i_cmd)
                        CMD_ADD: begin
                            if ((r_count >= CNT_W'(SLOTS)) || r_frozen) begin
                                n_valid  = 1'b1;
                                n_status = ST_FULL;
                            end else begin
                                n_state = S_PREP;
                            end
                        end
                        CMD_CLAIM: begin
                            if (i_slot_index >= 8'(r_count)) begin
                                n_valid  = 1'b1;
                                n_status = ST_BAD_INDEX;
                            end else begin
                                n_state = S_PREP;
                            end
                        end
                        CMD_FREEZE: begin
                            n_frozen = 1'b1;
                            n_locked = r_locked | w_mask;
                            n_valid  = 1'b1;
                            n_acc    = 1'b1;
                        end
                        default: begin
                            n_valid = 1'b1;
                            if (r_frozen) begin
                                n_late   = r_late + 32'd1;
                                n_fail   = FAIL_LATE;
                                n_status = ST_LATE;
                            end else begin
                                n_acc = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_PREP: begin
                n_end   = w_sum;
                n_carry = w_flags.carry;
                n_idx   = '0;
                n_state = (r_cmd == CMD_ADD) ? S_SCAN : S_CHK;
            end
            S_SCAN: begin
                n_cmp_vld = w_issue;
                if (w_issue) begin
                    n_idx = r_idx + CNT_W'(1);
                end
                if (r_cmp_vld && w_flags.gt0 && w_flags.gt1) begin
                    n_state  = S_IDLE;
                    n_valid  = 1'b1;
                    n_status = ST_OVERLAP;
                    n_fail   = FAIL_OVERLAP;
                end else if (!w_issue && !r_cmp_vld) begin
                    w_rg_we    = 1'b1;
                    w_mk_we    = 1'b1;
                    w_mk_waddr = r_count[IDX_W-1:0];
                    w_mk_wdata = {{ADDR_W{1'b0}}, {ADDR_W{1'b0}}, r_owner};
                    n_locked[r_count[IDX_W-1:0]] = 1'b0;
                    n_count    = r_count + CNT_W'(1);
                    n_state    = S_IDLE;
                    n_valid    = 1'b1;
                    n_acc      = 1'b1;
                end
            end
            S_CHK: begin
                if (r_carry || w_flags.gt0) begin
                    n_state  = S_IDLE;
                    n_valid  = 1'b1;
                    n_status = ST_OOB;
                    n_fail   = FAIL_OOB;
                end else begin
                    n_used  = w_flags.gt1 ? r_end : w_old_used;
                    n_state = S_PEAK;
                end
            end
            S_PEAK: begin
                w_mk_we = 1'b1;
                n_state = S_IDLE;
                n_valid = 1'b1;
                n_acc   = 1'b1;
                n_cu    = r_used;
                n_cp    = w_new_peak;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    rtog_ram #(.WIDTH(REG_W), .DEPTH(SLOTS)) u_region_ram (
        .i_clk   (i_clk),
        .i_we    (w_rg_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata ({r_a, r_b}),
        .i_raddr (w_raddr),
        .o_rdata (w_rg_rd)
    );

    rtog_ram #(.WIDTH(MARK_W), .DEPTH(SLOTS)) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (w_mk_we),
        .i_waddr (w_mk_waddr),
        .i_wdata (w_mk_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_mk_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cmp_vld <= 1'b0;
            r_count   <= '0;
            r_frozen  <= 1'b0;
            r_late    <= '0;
            r_fail    <= FAIL_NONE;
            r_locked  <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= n_cmp_vld;
            r_count   <= n_count;
            r_frozen  <= n_frozen;
            r_late    <= n_late;
            r_fail    <= n_fail;
            r_locked  <= n_locked;
            r_valid   <= n_valid;
        end
    end

    // hold the command payload for the whole transfer
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cmd   <= i_cmd;
            r_a     <= (i_cmd == CMD_CLAIM) ? i_claim_offset : i_region_base;
            r_b     <= (i_cmd == CMD_CLAIM) ? i_claim_length : i_region_size;
            r_owner <= i_owner_id;
            r_slot  <= i_slot_index[IDX_W-1:0];
        end
        r_end   <= n_end;
        r_carry <= n_carry;
        r_idx   <= n_idx;
        r_used  <= n_used;
        if (n_valid) begin
            r_acc    <= n_acc;
            r_status <= n_status;
            r_cu     <= n_cu;
            r_cp     <= n_cp;
        end
    end

    assign o_valid            = r_valid;
    assign o_accepted         = r_acc;
    assign o_status           = r_status;
    assign o_last_failure     = r_fail;
    assign o_claim_used       = r_cu;
    assign o_claim_peak       = r_cp;
    assign o_late_alloc_count = r_late;
    assign o_region_count     = 8'(r_count);

`include "region_table_overlap_guard_assert.svh"

    `RTOG_CHECK(a_strobe_idle, o_valid, !busy, "result strobe while busy")
    `RTOG_CHECK(a_lock_range, 1'b1, (r_locked >> r_count) == '0, "lock beyond stored count")
    `RTOG_CHECK_NEXT(a_count_add, w_take && (i_cmd != CMD_ADD), $stable(r_count), "count moved")

endmodule
